@@ sv/sll_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sll_pkg
// Shared widths, operation and status codes, and controller states for the
// static linked list engine.
// ----------------------------------------------------------------------------
package sll_pkg;

  localparam int NODES_DEF = 16;

  localparam int OP_W   = 2;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 8;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 4;
  localparam int LEN_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_FIND    = 2'd2,
    OP_REPLACE = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_FH,
    S_INS_NF,
    S_INS_WALK,
    S_INS_W1,
    S_INS_W2,
    S_SRCH_LINK,
    S_SRCH_CMP,
    S_DEL_FH,
    S_DEL_W,
    S_RESP
  } state_t;

endpackage

@@ sv/sll_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sll_in_if
// Request channel: valid/ready handshake carrying one list operation.
// ----------------------------------------------------------------------------
interface sll_in_if import sll_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;
  logic [VAL_W-1:0] new_value;

  modport source (output valid, op, position, value, new_value, input ready);
  modport sink   (input valid, op, position, value, new_value, output ready);
endinterface

@@ sv/sll_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sll_out_if
// Result channel: valid/ready handshake carrying status and slot.
// ----------------------------------------------------------------------------
interface sll_out_if import sll_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, status, slot, input ready);
  modport sink   (input valid, status, slot, output ready);
endinterface

@@ sv/sll_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sll_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/sll_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sll_ctrl
// Sequencer for the list engine: link chasing, search, node splice and
// free-list bookkeeping over the link and value memories.
// ----------------------------------------------------------------------------
module sll_ctrl import sll_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  sll_in_if.sink                   in_ch,
  sll_out_if.source                out_ch,
  output logic [$clog2(NODES)-1:0] mem_raddr,
  output logic                     link_we,
  output logic [$clog2(NODES)-1:0] link_waddr,
  output logic [$clog2(NODES)-1:0] link_wdata,
  input  logic [$clog2(NODES)-1:0] link_rdata,
  output logic                     value_we,
  output logic [$clog2(NODES)-1:0] value_waddr,
  output logic [VAL_W-1:0]         value_wdata,
  input  logic [VAL_W-1:0]         value_rdata
);

  localparam int LW = $clog2(NODES);
  localparam logic [LW-1:0] FREE_ANCHOR = '0;
  localparam logic [LW-1:0] HEAD        = LW'(1);
  localparam logic [LW-1:0] LAST        = LW'(NODES - 1);
  localparam logic [LW-1:0] FIRST_FREE  = (NODES > 2) ? LW'(2) : '0;

  state_t            state_r, state_nxt;
  logic [LW-1:0]     clr_r, clr_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              out_valid_r, out_valid_nxt;
  op_t               op_r, op_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [VAL_W-1:0]  nval_r, nval_nxt;
  logic [LW-1:0]     p_r, p_nxt;
  logic [LW-1:0]     c_r, c_nxt;
  logic [LW-1:0]     s_r, s_nxt;
  logic [LW-1:0]     t_r, t_nxt;
  logic [POS_W-1:0]  n_r, n_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [LW-1:0]     res_slot_r, res_slot_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [LW-1:0]     clr_data;
  logic [POS_W-1:0]  n_inc;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.slot   = out_slot_r;
  assign n_inc         = n_r + POS_W'(1);

  // reset image of the link store
  always_comb begin
    if (clr_r == FREE_ANCHOR) begin
      clr_data = FIRST_FREE;
    end else if (clr_r == HEAD || clr_r == LAST) begin
      clr_data = '0;
    end else begin
      clr_data = clr_r + LW'(1);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    len_nxt        = len_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    nval_nxt       = nval_r;
    p_nxt          = p_r;
    c_nxt          = c_r;
    s_nxt          = s_r;
    t_nxt          = t_r;
    n_nxt          = n_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    mem_raddr      = '0;
    link_we        = 1'b0;
    link_waddr     = '0;
    link_wdata     = '0;
    value_we       = 1'b0;
    value_waddr    = '0;
    value_wdata    = val_r;

    unique case (state_r)
      S_CLEAR: begin
        link_we    = 1'b1;
        link_waddr = clr_r;
        link_wdata = clr_data;
        clr_nxt    = clr_r + LW'(1);
        if (clr_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt       = op_t'(in_ch.op);
          pos_nxt      = in_ch.position;
          val_nxt      = in_ch.value;
          nval_nxt     = in_ch.new_value;
          p_nxt        = HEAD;
          n_nxt        = '0;
          res_slot_nxt = '0;
          if (in_ch.op == OP_INSERT) begin
            if (in_ch.position == '0 ||
                {1'b0, in_ch.position} > ({1'b0, len_r} + (LEN_W + 1)'(1))) begin
              res_status_nxt = ST_RANGE;
              state_nxt      = S_RESP;
            end else begin
              mem_raddr = FREE_ANCHOR;
              state_nxt = S_INS_FH;
            end
          end else begin
            mem_raddr = HEAD;
            state_nxt = S_SRCH_LINK;
          end
        end
      end
      S_INS_FH: begin
        if (link_rdata == '0) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_RESP;
        end else begin
          s_nxt     = link_rdata;
          mem_raddr = link_rdata;
          state_nxt = S_INS_NF;
        end
      end
      S_INS_NF: begin
        t_nxt     = link_rdata;
        n_nxt     = pos_r - POS_W'(1);
        mem_raddr = HEAD;
        state_nxt = S_INS_WALK;
      end
      S_INS_WALK: begin
        if (n_r == '0) begin
          c_nxt      = link_rdata;
          link_we    = 1'b1;
          link_waddr = FREE_ANCHOR;
          link_wdata = t_r;
          state_nxt  = S_INS_W1;
        end else begin
          p_nxt     = link_rdata;
          n_nxt     = n_r - POS_W'(1);
          mem_raddr = link_rdata;
        end
      end
      S_INS_W1: begin
        link_we     = 1'b1;
        link_waddr  = s_r;
        link_wdata  = c_r;
        value_we    = 1'b1;
        value_waddr = s_r;
        value_wdata = val_r;
        state_nxt   = S_INS_W2;
      end
      S_INS_W2: begin
        link_we        = 1'b1;
        link_waddr     = p_r;
        link_wdata     = s_r;
        len_nxt        = len_r + LEN_W'(1);
        res_status_nxt = ST_OK;
        res_slot_nxt   = s_r;
        state_nxt      = S_RESP;
      end
      S_SRCH_LINK: begin
        c_nxt = link_rdata;
        if (n_r < len_r && link_rdata != '0) begin
          mem_raddr = link_rdata;
          state_nxt = S_SRCH_CMP;
        end else begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_RESP;
        end
      end
      S_SRCH_CMP: begin
        if (value_rdata == val_r) begin
          res_status_nxt = ST_OK;
          res_slot_nxt   = c_r;
          state_nxt      = S_RESP;
          case (op_r)
            OP_DELETE: begin
              link_we    = 1'b1;
              link_waddr = p_r;
              link_wdata = link_rdata;
              mem_raddr  = FREE_ANCHOR;
              state_nxt  = S_DEL_FH;
            end
            OP_REPLACE: begin
              value_we    = 1'b1;
              value_waddr = c_r;
              value_wdata = nval_r;
            end
            default: begin
            end
          endcase
        end else begin
          p_nxt = c_r;
          c_nxt = link_rdata;
          n_nxt = n_inc;
          if (n_inc < len_r && link_rdata != '0) begin
            mem_raddr = link_rdata;
          end else begin
            res_status_nxt = ST_NOT_FOUND;
            state_nxt      = S_RESP;
          end
        end
      end
      S_DEL_FH: begin
        link_we    = 1'b1;
        link_waddr = c_r;
        link_wdata = link_rdata;
        state_nxt  = S_DEL_W;
      end
      S_DEL_W: begin
        link_we    = 1'b1;
        link_waddr = FREE_ANCHOR;
        link_wdata = c_r;
        if (len_r != '0) begin
          len_nxt = len_r - LEN_W'(1);
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = SLOT_W'(res_slot_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    nval_r       <= nval_nxt;
    p_r          <= p_nxt;
    c_r          <= c_nxt;
    s_r          <= s_nxt;
    t_r          <= t_nxt;
    n_r          <= n_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

endmodule

@@ sv/static_linked_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// static_linked_list_engine
// Cursor-linked byte list in a fixed node store with a free list.
//
// in_ch takes one request per transaction (insert at position, delete,
// find or replace by value); out_ch returns one status/slot transaction
// per request, in order. Both are valid/ready channels.
// Requests are handled one at a time. From accept to result valid:
//   insert:  walk of the link memory to the splice point
//   find/replace: walk to the match, or over the whole list when absent
//            (one node read per cycle)
//   delete:  as find, then two more link writes to return the node
// The engine returns to idle before the next accept;
// the single read port of the link memory sets the walk rate. A range error
// returns without a walk, as does a full store.
// After reset the link memory is initialized one entry per cycle, with
// in_ch.ready low. A stalled result sits in the output register;
// the next request is still accepted and runs until its own result is ready.
// ----------------------------------------------------------------------------
module static_linked_list_engine import sll_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sll_in_if.sink    in_ch,
  sll_out_if.source out_ch
);

  localparam int LW = $clog2(NODES);

  logic [LW-1:0]    mem_raddr;
  logic             link_we;
  logic [LW-1:0]    link_waddr;
  logic [LW-1:0]    link_wdata;
  logic [LW-1:0]    link_rdata;
  logic             value_we;
  logic [LW-1:0]    value_waddr;
  logic [VAL_W-1:0] value_wdata;
  logic [VAL_W-1:0] value_rdata;

  sll_ctrl #(
    .NODES (NODES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mem_raddr   (mem_raddr),
    .link_we     (link_we),
    .link_waddr  (link_waddr),
    .link_wdata  (link_wdata),
    .link_rdata  (link_rdata),
    .value_we    (value_we),
    .value_waddr (value_waddr),
    .value_wdata (value_wdata),
    .value_rdata (value_rdata)
  );

  sll_ram #(
    .WIDTH (LW),
    .DEPTH (NODES)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (mem_raddr),
    .rdata (link_rdata)
  );

  sll_ram #(
    .WIDTH (VAL_W),
    .DEPTH (NODES)
  ) u_value_ram (
    .clk   (clk),
    .we    (value_we),
    .waddr (value_waddr),
    .wdata (value_wdata),
    .raddr (mem_raddr),
    .rdata (value_rdata)
  );

endmodule
